// ===== design/rpl_pkg.sv =====
package rpl_pkg;

  localparam int unsigned DEF_SAMPLE_BITS      = 24;
  localparam int unsigned DEF_MAX_BLOCK_FRAMES = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned GAIN_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY_GAIN = 3'd4;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic MODE_MONO   = 1'b0;
  localparam logic MODE_STEREO = 1'b1;

  localparam logic [COEF_W-1:0] ONE_Q16           = 17'h10000;
  localparam logic [COEF_W-1:0] ATTACK_COEF_RST   = 17'h10000;
  localparam logic [COEF_W-1:0] RELEASE_COEF_RST  = 17'h08000;
  localparam logic [GAIN_W-1:0] PEAK_DECAY_RST    = 16'd62134;
  localparam int unsigned       BLOCK_FRAMES_RST  = 512;

endpackage

// ===== design/block_rms_peak_level_meter.sv =====
// Push frame: the input is busy while the bit-serial squarer runs.
// Block-ending frame: adds the bit-serial divide, the root and the smoothing
// multiply.
// Clear request: handled in the idle state. One frame in flight at a time; the result register frees the input.
// Reset (async, active low): levels and accumulators zero, registers to their defaults.
module block_rms_peak_level_meter #(
  parameter int unsigned SAMPLE_BITS      = rpl_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned MAX_BLOCK_FRAMES = rpl_pkg::DEF_MAX_BLOCK_FRAMES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rpl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rpl_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic signed [SAMPLE_BITS-1:0]    left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]    right_sample_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [SAMPLE_BITS-1:0]           rms_level_o,
  output logic [SAMPLE_BITS-1:0]           peak_level_o
);
  import rpl_pkg::*;

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned FRAME_W = $clog2(MAX_BLOCK_FRAMES) + 1;
  localparam int unsigned SUM_W   = 2 * SB - 1 + $clog2(MAX_BLOCK_FRAMES);
  localparam int unsigned QW      = 2 * SB - 1;
  localparam logic [FRAME_W-1:0] MAX_LEN = FRAME_W'(MAX_BLOCK_FRAMES);
  localparam logic [SB-1:0] PEAK_FLOOR =
    SB'(((64'd1 << (SAMPLE_BITS - 1)) + 64'd9999) / 64'd10000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_ROOT,
    ST_SMOOTH,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic               mode_q;
  logic [FRAME_W-1:0] frames_q;
  logic [COEF_W-1:0]  attack_q;
  logic [COEF_W-1:0]  release_q;
  logic [GAIN_W-1:0]  gain_q;

  logic [SUM_W-1:0]   square_sum_q;
  logic [FRAME_W-1:0] frame_count_q;
  logic [SB-1:0]      block_max_q;
  logic [SB-1:0]      max_blk_q;
  logic [SB-1:0]      mag_q;
  logic [SB-1:0]      rms_held_q;
  logic [SB-1:0]      peak_held_q;
  logic               out_valid_q;
  logic [SB-1:0]      rms_out_q;
  logic [SB-1:0]      peak_out_q;

  logic               in_accept;
  logic               out_load;
  logic               sq_start, div_start, root_start, mac_start;
  logic               sq_done, div_done, root_done, sm_done, pk_done;
  logic [SB:0]        sq_hi;
  logic [SB-1:0]      sq_lo;
  logic [SUM_W-1:0]   quo;
  logic [SB-1:0]      cur;
  logic [SB:0]        sm_hi, pk_hi;
  logic [COEF_W-1:0]  sm_lo, pk_lo;

  logic [SB:0]        lr_sum;
  logic [SB-1:0]      mono;
  logic [SB-1:0]      mag_d;
  logic [FRAME_W-1:0] len;
  logic [FRAME_W-1:0] count_d;
  logic [SUM_W-1:0]   sum_d;
  logic [SB-1:0]      max_d;
  logic               block_end;
  logic [COEF_W-1:0]  w_d, wc_d;
  logic [COEF_W:0]    rnd;
  logic [SB-1:0]      rms_d;
  logic [SB-1:0]      pk_dec;
  logic [SB-1:0]      peak_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    lr_sum = {left_sample_i[SB-1], left_sample_i} + {right_sample_i[SB-1], right_sample_i};
    mono   = (mode_q == MODE_STEREO) ? lr_sum[SB:1] : left_sample_i;
    mag_d  = mono[SB-1] ? (~mono + SB'(1)) : mono;

    if (frames_q == '0) begin
      len = FRAME_W'(1);
    end else if (frames_q > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = frames_q;
    end

    count_d   = frame_count_q + FRAME_W'(1);
    sum_d     = square_sum_q + SUM_W'({sq_hi, sq_lo});
    max_d     = (mag_q > block_max_q) ? mag_q : block_max_q;
    block_end = (count_d >= len);

    if (attack_q[COEF_W-1]) begin
      w_d = ONE_Q16;
    end else if (cur > rms_held_q) begin
      w_d = attack_q;
    end else if (release_q > ONE_Q16) begin
      w_d = ONE_Q16;
    end else begin
      w_d = release_q;
    end
    wc_d = ONE_Q16 - w_d;

    // round the Q16 blend: hi carries bits 17 and up of the product
    rnd    = {1'b0, sm_lo} + (COEF_W + 1)'(32768);
    rms_d  = SB'({sm_hi, 1'b0} + (SB + 2)'(rnd[COEF_W:COEF_W-1]));
    pk_dec = SB'({pk_hi, pk_lo[COEF_W-1]});
    if (max_blk_q > peak_held_q) begin
      peak_d = max_blk_q;
    end else if (pk_dec < PEAK_FLOOR) begin
      peak_d = '0;
    end else begin
      peak_d = pk_dec;
    end
  end

  assign sq_start   = in_accept && (action_i == ACT_PUSH);
  assign div_start  = (state_q == ST_SQUARE) && sq_done && block_end;
  assign root_start = (state_q == ST_DIVIDE) && div_done;
  assign mac_start  = (state_q == ST_ROOT) && root_done;

  rpl_mac #(.MW(SB), .DW(SB)) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .a_i     (mag_d),
    .x_i     (mag_d),
    .b_i     ('0),
    .y_i     ('0),
    .done_o  (sq_done),
    .hi_o    (sq_hi),
    .lo_o    (sq_lo)
  );

  rpl_div #(.NW(SUM_W), .DW(FRAME_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_d),
    .den_i   (count_d),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  rpl_sqrt #(.RB(SB)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   ({1'b0, quo[QW-1:0]}),
    .done_o  (root_done),
    .root_o  (cur)
  );

  rpl_mac #(.MW(COEF_W), .DW(SB)) u_smooth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     (w_d),
    .x_i     (cur),
    .b_i     (wc_d),
    .y_i     (rms_held_q),
    .done_o  (sm_done),
    .hi_o    (sm_hi),
    .lo_o    (sm_lo)
  );

  rpl_mac #(.MW(COEF_W), .DW(SB)) u_decay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     ({1'b0, gain_q}),
    .x_i     (peak_held_q),
    .b_i     ('0),
    .y_i     ('0),
    .done_o  (pk_done),
    .hi_o    (pk_hi),
    .lo_o    (pk_lo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= MODE_MONO;
      frames_q      <= FRAME_W'(BLOCK_FRAMES_RST);
      attack_q      <= ATTACK_COEF_RST;
      release_q     <= RELEASE_COEF_RST;
      gain_q        <= PEAK_DECAY_RST;
      square_sum_q  <= '0;
      frame_count_q <= '0;
      block_max_q   <= '0;
      max_blk_q     <= '0;
      mag_q         <= '0;
      rms_held_q    <= '0;
      peak_held_q   <= '0;
      out_valid_q   <= 1'b0;
      rms_out_q     <= '0;
      peak_out_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CHANNEL_MODE:    mode_q    <= cfg_data_i[0];
          CFG_BLOCK_FRAMES:    frames_q  <= cfg_data_i[FRAME_W-1:0];
          CFG_ATTACK_COEF:     attack_q  <= cfg_data_i[COEF_W-1:0];
          CFG_RELEASE_COEF:    release_q <= cfg_data_i[COEF_W-1:0];
          CFG_PEAK_DECAY_GAIN: gain_q    <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end

      // refill in the cycle the old result leaves
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (action_i == ACT_CLEAR) begin
              square_sum_q  <= '0;
              frame_count_q <= '0;
              block_max_q   <= '0;
              rms_held_q    <= '0;
              peak_held_q   <= '0;
            end else begin
              mag_q   <= mag_d;
              state_q <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          if (sq_done) begin
            if (block_end) begin
              square_sum_q  <= '0;
              frame_count_q <= '0;
              block_max_q   <= '0;
              max_blk_q     <= max_d;
              state_q       <= ST_DIVIDE;
            end else begin
              square_sum_q  <= sum_d;
              frame_count_q <= count_d;
              block_max_q   <= max_d;
              state_q       <= ST_IDLE;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            state_q <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          if (sm_done && pk_done) begin
            rms_held_q  <= rms_d;
            peak_held_q <= peak_d;
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the result register is free
          if (out_load) begin
            rms_out_q   <= rms_held_q;
            peak_out_q  <= peak_held_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rms_level_o  = rms_out_q;
  assign peak_level_o = peak_out_q;

endmodule

// ===== design/rpl_mac.sv =====
module rpl_mac #(
  parameter int unsigned MW = 17,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] a_i,
  input  logic [DW-1:0] x_i,
  input  logic [MW-1:0] b_i,
  input  logic [DW-1:0] y_i,
  output logic          done_o,
  output logic [DW:0]   hi_o,
  output logic [MW-1:0] lo_o
);
  import rpl_pkg::*;

  localparam int unsigned CW = $clog2(MW + 1);

  logic [MW-1:0] ma_q, mb_q;
  logic [DW-1:0] x_q, y_q;
  logic [DW:0]   hi_q;
  logic [MW-1:0] lo_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW+1:0] sum_d;

  // a*x + b*y, one bit of each multiplier per cycle, LSB first
  always_comb begin
    sum_d = {1'b0, hi_q}
          + (ma_q[0] ? {2'b00, x_q} : '0)
          + (mb_q[0] ? {2'b00, y_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(MW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q <= a_i;
      mb_q <= b_i;
      x_q  <= x_i;
      y_q  <= y_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (cnt_q != '0) begin
      ma_q <= ma_q >> 1;
      mb_q <= mb_q >> 1;
      hi_q <= sum_d[DW+1:1];
      lo_q <= {sum_d[0], lo_q[MW-1:1]};
    end
  end

  assign done_o = done_q;
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

endmodule

// ===== design/rpl_div.sv =====
module rpl_div #(
  parameter int unsigned NW = 59,
  parameter int unsigned DW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  import rpl_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== design/rpl_sqrt.sv =====
module rpl_sqrt #(
  parameter int unsigned RB = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RB-1:0] rad_i,
  output logic            done_o,
  output logic [RB-1:0]   root_o
);
  import rpl_pkg::*;

  localparam int unsigned CW = $clog2(RB + 1);

  logic [2*RB-1:0] rad_q;
  logic [RB-1:0]   root_q;
  logic [RB+1:0]   rem_q;
  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic [RB+3:0]   cand;
  logic [RB+3:0]   trial;
  logic [RB+3:0]   diff;
  logic            ge;

  // digit-by-digit root: two radicand bits in, one root bit out per cycle
  always_comb begin
    cand  = {rem_q, rad_q[2*RB-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    diff  = cand - trial;
    ge    = cand >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(RB);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      root_q <= {root_q[RB-2:0], ge};
      rem_q  <= ge ? diff[RB+1:0] : cand[RB+1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sim/block_rms_peak_level_meter_tb.sv =====
module block_rms_peak_level_meter_tb;
  import rpl_pkg::*;

  localparam int unsigned     SB              = DEF_SAMPLE_BITS;
  localparam int unsigned     MAX_FRAMES      = DEF_MAX_BLOCK_FRAMES;
  localparam longint unsigned FULL_SCALE      = 64'd1 << (SB - 1);
  localparam longint unsigned PEAK_FLOOR      = (FULL_SCALE + 9999) / 10000;
  localparam int unsigned     SETTLE_CYCLES   = 300;
  localparam int unsigned     HOLD_OFF_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int unsigned     RANDOM_ITEMS    = 120;

  typedef longint unsigned u64_t;
  typedef logic signed [SB-1:0] sample_t;
  typedef struct packed {
    logic [SB-1:0] rms;
    logic [SB-1:0] peak;
  } levels_t;
  typedef struct {
    logic        mode;
    int unsigned frames;
    int unsigned attack;
    int unsigned rel;
    int unsigned gain;
  } meter_cfg_t;

  localparam sample_t MAX_POS = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t MAX_NEG = {1'b1, {(SB-1){1'b0}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  sample_t               left_sample_i;
  sample_t               right_sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [SB-1:0]         rms_level_o;
  logic [SB-1:0]         peak_level_o;

  block_rms_peak_level_meter dut (.*);

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // meter state as the block should hold it
  logic        m_mode;
  int unsigned m_frames, m_attack, m_release, m_gain;
  u64_t        acc_sq, acc_max, held_rms, held_peak;
  int unsigned acc_n;

  levels_t levels_due[$];

  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned errors       = 0;
  int unsigned n_items      = 0;
  int unsigned n_clears     = 0;
  int unsigned n_results    = 0;
  int unsigned n_writes     = 0;
  u64_t        cycles       = 0;

  function automatic void clear_meter();
    acc_sq    = 0;
    acc_n     = 0;
    acc_max   = 0;
    held_rms  = 0;
    held_peak = 0;
  endfunction

  function automatic u64_t int_root(input u64_t x);
    u64_t r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (u64_t'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic u64_t blend(input u64_t cur, input u64_t held, input u64_t w);
    return (w * cur + (u64_t'(ONE_Q16) - w) * held + 32768) >> 16;
  endfunction

  function automatic void predict_levels(input logic act, input sample_t l, input sample_t r);
    longint mono;
    u64_t   mag, len, cur, w;
    if (act == ACT_CLEAR) begin
      clear_meter();
      n_clears++;
      return;
    end
    if (m_mode == MODE_STEREO) mono = (longint'(l) + longint'(r)) >>> 1;
    else mono = longint'(l);
    mag = (mono < 0) ? u64_t'(-mono) : u64_t'(mono);
    if (mag > acc_max) acc_max = mag;
    acc_sq += mag * mag;
    acc_n++;
    len = (m_frames == 0) ? 1 : ((m_frames > MAX_FRAMES) ? MAX_FRAMES : m_frames);
    if (acc_n < len) return;

    cur = int_root(acc_sq / acc_n);
    if (m_attack >= ONE_Q16) begin
      held_rms = cur;
    end else if (cur > held_rms) begin
      held_rms = blend(cur, held_rms, m_attack);
    end else begin
      w = (m_release > ONE_Q16) ? u64_t'(ONE_Q16) : u64_t'(m_release);
      held_rms = blend(cur, held_rms, w);
    end
    if (acc_max > held_peak) begin
      held_peak = acc_max;
    end else begin
      held_peak = (held_peak * m_gain) >> 16;
      if (held_peak < PEAK_FLOOR) held_peak = 0;
    end
    acc_sq  = 0;
    acc_n   = 0;
    acc_max = 0;
    levels_due.push_back('{rms: held_rms[SB-1:0], peak: held_peak[SB-1:0]});
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic sample_t smp(input int v);
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return MAX_POS;
      1:       return MAX_NEG;
      2:       return '0;
      3:       return smp(-1);
      4, 5:    return smp(int'($urandom_range(0, 2000)) - 1000);
      6:       return smp(int'($urandom_range(0, 65536)) - 32768);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic push_request(input logic act, input sample_t l, input sample_t r);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    left_sample_i  <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict_levels(act, l, r);
    n_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CHANNEL_MODE:    m_mode    = val[0];
      CFG_BLOCK_FRAMES:    m_frames  = val[12:0];
      CFG_ATTACK_COEF:     m_attack  = val[16:0];
      CFG_RELEASE_COEF:    m_release = val[16:0];
      CFG_PEAK_DECAY_GAIN: m_gain    = val[15:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // only while idle: valid stays high across the five writes
  task automatic set_config(input meter_cfg_t c);
    write_reg(CFG_CHANNEL_MODE, c.mode);
    write_reg(CFG_BLOCK_FRAMES, c.frames);
    write_reg(CFG_ATTACK_COEF, c.attack);
    write_reg(CFG_RELEASE_COEF, c.rel);
    write_reg(CFG_PEAK_DECAY_GAIN, c.gain);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every due result, then let a partial frame finish its squaring
  task automatic settle();
    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < BLOCK_FRAMES_RST; i++)
      push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
  endtask

  task automatic test_single_frame_extremes();
    set_config('{mode: MODE_MONO, frames: 0, attack: ONE_Q16, rel: RELEASE_COEF_RST,
                 gain: PEAK_DECAY_RST});
    push_request(ACT_PUSH, MAX_POS, pick_sample());
    push_request(ACT_PUSH, MAX_NEG, MAX_POS);
    push_request(ACT_PUSH, '0, MAX_NEG);
    push_request(ACT_PUSH, smp(-1), pick_sample());
    push_request(ACT_PUSH, smp(1), smp(-1));
    push_request(ACT_CLEAR, pick_sample(), pick_sample());
    push_request(ACT_PUSH, '0, '0);
    push_request(ACT_PUSH, smp(3000), pick_sample());
    settle();
  endtask

  task automatic test_stereo_average();
    set_config('{mode: MODE_STEREO, frames: 2, attack: ONE_Q16, rel: 0, gain: 65535});
    push_request(ACT_PUSH, MAX_POS, MAX_POS);
    push_request(ACT_PUSH, MAX_NEG, MAX_NEG);
    // odd sums round toward minus infinity
    push_request(ACT_PUSH, smp(-1), smp(0));
    push_request(ACT_PUSH, smp(3), smp(-4));
    push_request(ACT_PUSH, MAX_POS, MAX_NEG);
    push_request(ACT_PUSH, MAX_NEG, MAX_POS);
    settle();
  endtask

  task automatic test_smoothing();
    // release weight above one acts as one; zero gain drops the peak at once
    set_config('{mode: MODE_MONO, frames: 1, attack: 0, rel: 131071, gain: 0});
    push_request(ACT_PUSH, smp(4000000), '0);
    push_request(ACT_PUSH, MAX_POS, '0);
    push_request(ACT_PUSH, '0, '0);
    settle();
    set_config('{mode: MODE_MONO, frames: 1, attack: 1000, rel: 0, gain: 65535});
    push_request(ACT_PUSH, MAX_POS, '0);
    push_request(ACT_PUSH, smp(100), '0);
    settle();
    set_config('{mode: MODE_MONO, frames: 1, attack: 65535, rel: ONE_Q16, gain: 30000});
    push_request(ACT_PUSH, MAX_NEG, '0);
    push_request(ACT_PUSH, smp(1000), '0);
    settle();
  endtask

  task automatic test_length_change();
    set_config('{mode: MODE_MONO, frames: MAX_FRAMES, attack: ONE_Q16,
                 rel: RELEASE_COEF_RST, gain: PEAK_DECAY_RST});
    repeat (4) push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
    // shorter length ends the open block on its next frame
    set_config('{mode: MODE_MONO, frames: 2, attack: ONE_Q16,
                 rel: RELEASE_COEF_RST, gain: PEAK_DECAY_RST});
    push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
    set_config('{mode: MODE_STEREO, frames: 8191, attack: 40000, rel: 20000, gain: 60000});
    repeat (2) push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
    set_config('{mode: MODE_STEREO, frames: 1, attack: 40000, rel: 20000, gain: 60000});
    push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
    // clear in the middle of a block restarts the count
    set_config('{mode: MODE_MONO, frames: 3, attack: 40000, rel: 20000, gain: 60000});
    push_request(ACT_PUSH, MAX_NEG, '0);
    push_request(ACT_CLEAR, pick_sample(), pick_sample());
    repeat (3) push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
  endtask

  task automatic test_full_block();
    // every frame at the most negative value: largest square on each frame
    set_config('{mode: MODE_STEREO, frames: 48, attack: ONE_Q16, rel: 0, gain: 0});
    quiet = 1'b1;
    repeat (48) push_request(ACT_PUSH, MAX_NEG, MAX_NEG);
    settle();
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_config('{mode: MODE_MONO, frames: 1, attack: 20000, rel: 40000, gain: 50000});
    hold_off_req = 1'b1;
    repeat (20) push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
    repeat (10) push_request(ACT_PUSH, pick_sample(), pick_sample());
    settle();
  endtask

  task automatic test_random_traffic();
    meter_cfg_t  c;
    int unsigned sent, n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      c.mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:          c.frames = 0;
        1, 2, 3, 4: c.frames = $urandom_range(1, 3);
        5, 6, 7:    c.frames = $urandom_range(4, 12);
        8:          c.frames = $urandom_range(13, 40);
        default:    c.frames = 1;
      endcase
      case ($urandom_range(0, 3))
        0:       c.attack = ONE_Q16;
        1:       c.attack = 0;
        2:       c.attack = $urandom_range(0, 65536);
        default: c.attack = $urandom_range(60000, 131071);
      endcase
      case ($urandom_range(0, 3))
        0:       c.rel = 0;
        1:       c.rel = ONE_Q16;
        default: c.rel = $urandom_range(0, 131071);
      endcase
      c.gain = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 65535);
      set_config(c);
      quiet = ($urandom_range(0, 5) == 0);
      n = $urandom_range(40, 90);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 29) == 0)
          push_request(ACT_CLEAR, pick_sample(), pick_sample());
        else
          push_request(ACT_PUSH, pick_sample(), pick_sample());
      end
      sent += n;
      settle();
      quiet = 1'b0;
    end
  endtask

  initial begin : receiver
    int unsigned stall_left, hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : check_levels
    levels_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected result rms_level %0d peak_level %0d",
                 $time, rms_level_o, peak_level_o);
        errors++;
      end else begin
        want = levels_due.pop_front();
        if (rms_level_o !== want.rms) begin
          $display("%0t: rms_level expected %0d got %0d", $time, want.rms, rms_level_o);
          errors++;
        end
        if (peak_level_o !== want.peak) begin
          $display("%0t: peak_level expected %0d got %0d", $time, want.peak, peak_level_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still due", $time, levels_due.size());
      $display("block_rms_peak_level_meter_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    action_i       = ACT_PUSH;
    left_sample_i  = '0;
    right_sample_i = '0;
    m_mode    = MODE_MONO;
    m_frames  = BLOCK_FRAMES_RST;
    m_attack  = ATTACK_COEF_RST;
    m_release = RELEASE_COEF_RST;
    m_gain    = PEAK_DECAY_RST;
    clear_meter();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_single_frame_extremes();
    test_stereo_average();
    test_smoothing();
    test_length_change();
    test_full_block();
    test_backpressure();
    test_random_traffic();

    $display("%0d requests (%0d clears), %0d level results checked, %0d register writes",
             n_items, n_clears, n_results, n_writes);
    $display("mono and stereo, block lengths 0 to 8191 incl. clamped, full-scale block, hold-off");
    if (errors == 0)
      $display("block_rms_peak_level_meter_tb OK");
    else
      $display("block_rms_peak_level_meter_tb NOT OK");
    $finish;
  end

endmodule
